// ----- rtl/core/lgs_pkg.sv -----
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants, widths and register codes of the LDA topic sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package lgs_pkg;

   // default sizes of the count stores
   localparam int LGS_MAX_TOPICS = 32;
   localparam int LGS_MAX_VOCAB  = 1024;
   localparam int LGS_MAX_DOCS   = 256;
   localparam int LGS_COUNT_BITS = 16;

   // fixed datapath widths
   localparam int FRAC_W  = 16;   // Q.16 fraction bits
   localparam int TOT_W   = 24;   // topic total counts
   localparam int WGT_W   = 48;   // weights and cumulative sums, Q32.16
   localparam int DIV_W   = 41;   // divisor (nk << 16) + V*beta
   localparam int DIGIT_W = 8;    // multiplier digit per cycle
   localparam int RAND_W  = 32;

   // request / response field widths
   localparam int DOC_W   = 8;
   localparam int WORD_W  = 10;
   localparam int TOPIC_W = 5;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int NTOP_W     = 6;
   localparam int VSIZE_W    = 11;
   localparam int PRIOR_W    = 24;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_TOPICS = 2'd0,
      CSR_VOCAB_SIZE = 2'd1,
      CSR_ALPHA      = 2'd2,
      CSR_BETA       = 2'd3
   } csr_idx_type;

   localparam logic [NTOP_W-1:0]  NTOP_RST  = 6'd32;
   localparam logic [VSIZE_W-1:0] VSIZE_RST = 11'd1024;
   localparam logic [PRIOR_W-1:0] ALPHA_RST = 24'd65536;
   localparam logic [PRIOR_W-1:0] BETA_RST  = 24'd655;

   // index width of a store of n entries, at least one bit
   function automatic int idx_w(int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/lgs_mul.sv -----
// ----------------------------------------------------------------------------
// lgs_mul
// Digit-serial unsigned multiplier, one 8-bit digit of b per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_mul import lgs_pkg::*; #(
   parameter int A_W = 33,
   parameter int B_W = 33
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [A_W-1:0]     a,
   input  wire logic [B_W-1:0]     b,
   output logic                    done,
   output logic [A_W+B_W-1:0]      product
);

   localparam int ND    = (B_W + DIGIT_W - 1) / DIGIT_W;
   localparam int BP_W  = ND * DIGIT_W;
   localparam int ACC_W = A_W + BP_W;
   localparam int CNT_W = $clog2(ND + 1);

   logic [A_W-1:0]         a_ff, a_in;
   logic [BP_W-1:0]        b_ff, b_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   done_ff, done_in;
   logic [A_W+DIGIT_W-1:0] pp;

   // shift-accumulate one digit
   always_comb begin
      pp      = (A_W+DIGIT_W)'(a_ff) * (A_W+DIGIT_W)'(b_ff[BP_W-1 -: DIGIT_W]);
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         a_in   = a;
         b_in   = BP_W'(b);
         acc_in = '0;
         cnt_in = CNT_W'(ND);
      end else if (cnt_ff != '0) begin
         acc_in  = (acc_ff << DIGIT_W) + ACC_W'(pp);
         b_in    = b_ff << DIGIT_W;
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff[A_W+B_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/lgs_div.sv -----
// ----------------------------------------------------------------------------
// lgs_div
// Restoring divider, one quotient bit per cycle, with quotient overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_div import lgs_pkg::*; #(
   parameter int N_W = 66,
   parameter int D_W = DIV_W,
   parameter int Q_W = WGT_W
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [N_W-1:0] dividend,
   input  wire logic [D_W-1:0] divisor,
   output logic                done,
   output logic [Q_W-1:0]      quotient,
   output logic [D_W-1:0]      remainder,
   output logic                overflow
);

   localparam int CNT_W = $clog2(N_W + 1);

   logic [N_W-1:0]   n_ff, n_in;
   logic [D_W-1:0]   d_ff, d_in;
   logic [D_W-1:0]   r_ff, r_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [D_W:0]     trial;
   logic [D_W:0]     diff;
   logic             ge;

   // one trial subtraction per cycle
   always_comb begin
      trial   = {r_ff, n_ff[N_W-1]};
      diff    = trial - {1'b0, d_ff};
      ge      = (trial >= {1'b0, d_ff});
      n_in    = n_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         n_in   = dividend;
         d_in   = divisor;
         r_in   = '0;
         q_in   = '0;
         ovf_in = 1'b0;
         cnt_in = CNT_W'(N_W);
      end else if (cnt_ff != '0) begin
         n_in    = n_ff << 1;
         r_in    = ge ? diff[D_W-1:0] : trial[D_W-1:0];
         q_in    = {q_ff[Q_W-2:0], ge};
         // a set bit at or above the quotient width sets the overflow flag
         ovf_in  = ovf_ff | (ge & (cnt_ff > CNT_W'(Q_W)));
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      d_ff   <= d_in;
      r_ff   <= r_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;
   assign overflow  = ovf_ff;

endmodule

`default_nettype wire

// ----- rtl/core/lgs_counts.sv -----
// ----------------------------------------------------------------------------
// lgs_counts
// Count stores: document-topic and topic-word memories with a clearing pass
// after reset, and topic totals with per-entry valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_counts import lgs_pkg::*; #(
   parameter int MAX_TOPICS = LGS_MAX_TOPICS,
   parameter int MAX_VOCAB  = LGS_MAX_VOCAB,
   parameter int MAX_DOCS   = LGS_MAX_DOCS,
   parameter int COUNT_BITS = LGS_COUNT_BITS,
   localparam int DX_W = idx_w(MAX_DOCS),
   localparam int WX_W = idx_w(MAX_VOCAB),
   localparam int TX_W = idx_w(MAX_TOPICS)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [DX_W-1:0]       doc,
   input  wire logic [WX_W-1:0]       word,
   input  wire logic [TX_W-1:0]       topic,
   input  wire logic                  wr_en,
   input  wire logic [COUNT_BITS-1:0] dt_wdata,
   input  wire logic [COUNT_BITS-1:0] tw_wdata,
   input  wire logic [TOT_W-1:0]      tt_wdata,
   output logic [COUNT_BITS-1:0]      dt_q,
   output logic [COUNT_BITS-1:0]      tw_q,
   output logic [TOT_W-1:0]           tt_q,
   output logic                       clear_done
);

   localparam int DT_DEPTH = MAX_DOCS * MAX_TOPICS;
   localparam int TW_DEPTH = MAX_TOPICS * MAX_VOCAB;
   localparam int DT_AW    = idx_w(DT_DEPTH);
   localparam int TW_AW    = idx_w(TW_DEPTH);
   localparam int CLR_N    = (DT_DEPTH > TW_DEPTH) ? DT_DEPTH : TW_DEPTH;
   localparam int CLR_W    = idx_w(CLR_N);

   logic [COUNT_BITS-1:0] dt_mem [DT_DEPTH];
   logic [COUNT_BITS-1:0] tw_mem [TW_DEPTH];
   logic [TOT_W-1:0]      tt_mem [MAX_TOPICS];
   logic [MAX_TOPICS-1:0] tt_vld_ff;

   logic [CLR_W-1:0]      clr_ff, clr_in;
   logic                  clearing_ff, clearing_in;
   logic [DT_AW-1:0]      dt_addr, dt_waddr;
   logic [TW_AW-1:0]      tw_addr, tw_waddr;
   logic                  dt_we, tw_we;
   logic [COUNT_BITS-1:0] dt_wd, tw_wd;
   logic [COUNT_BITS-1:0] dt_q_ff, tw_q_ff;
   logic [TOT_W-1:0]      tt_q_ff;
   logic                  tt_vq_ff;

   // entry addresses
   assign dt_addr = DT_AW'(DT_AW'(doc) * DT_AW'(MAX_TOPICS) + DT_AW'(topic));
   assign tw_addr = TW_AW'(TW_AW'(topic) * TW_AW'(MAX_VOCAB) + TW_AW'(word));

   // clearing pass walks both memories once after reset
   always_comb begin
      clr_in      = clr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == CLR_W'(CLR_N - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (clearing_ff) begin
         dt_we    = ({1'b0, clr_ff} < (CLR_W+1)'(DT_DEPTH));
         tw_we    = ({1'b0, clr_ff} < (CLR_W+1)'(TW_DEPTH));
         dt_waddr = clr_ff[DT_AW-1:0];
         tw_waddr = clr_ff[TW_AW-1:0];
         dt_wd    = '0;
         tw_wd    = '0;
      end else begin
         dt_we    = wr_en;
         tw_we    = wr_en;
         dt_waddr = dt_addr;
         tw_waddr = tw_addr;
         dt_wd    = dt_wdata;
         tw_wd    = tw_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clearing_ff <= 1'b1;
         tt_vld_ff   <= '0;
      end else begin
         clr_ff      <= clr_in;
         clearing_ff <= clearing_in;
         if (wr_en) begin
            tt_vld_ff[topic] <= 1'b1;
         end
      end
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (dt_we) begin
         dt_mem[dt_waddr] <= dt_wd;
      end
      dt_q_ff <= dt_mem[dt_addr];
   end

   always_ff @(posedge clock) begin
      if (tw_we) begin
         tw_mem[tw_waddr] <= tw_wd;
      end
      tw_q_ff <= tw_mem[tw_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tt_mem[topic] <= tt_wdata;
      end
      tt_q_ff  <= tt_mem[topic];
      tt_vq_ff <= tt_vld_ff[topic];
   end

   assign dt_q       = dt_q_ff;
   assign tw_q       = tw_q_ff;
   assign tt_q       = tt_vq_ff ? tt_q_ff : '0;
   assign clear_done = ~clearing_ff;

endmodule

`default_nettype wire

// ----- rtl/core/lda_gibbs_topic_sampler.sv -----
// ----------------------------------------------------------------------------
// lda_gibbs_topic_sampler
// Collapsed Gibbs topic sampler: assigns or resamples the topic of one token
// and keeps the document-topic, topic-word and topic-total counts.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   req_action .. req_random_*     start, taken when busy is low
//  response  rsp_new_topic, rsp_count_error rsp_valid, one cycle, no stall
//  config    csr_index, csr_data            csr_write, taken every cycle
//
//  One request at a time. Assign keeps busy high from the taking edge
//  through index wrap, a 66-step modulo in the shared divider and one
//  read-modify-write; rsp_valid rises in the same cycle that busy falls.
//  Resample keeps busy high through index wrap, the old-topic modulo, its
//  removal, a weight loop over the topics in use (digit-serial multiply,
//  then the 66-step divide, per topic), the threshold multiply, the compare
//  pass and the final add; response as for assign. After reset the count
//  memories are cleared; busy stays high meanwhile. Responses cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module lda_gibbs_topic_sampler import lgs_pkg::*; #(
   parameter int MAX_TOPICS = LGS_MAX_TOPICS,
   parameter int MAX_VOCAB  = LGS_MAX_VOCAB,
   parameter int MAX_DOCS   = LGS_MAX_DOCS,
   parameter int COUNT_BITS = LGS_COUNT_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_action,
   input  wire logic [DOC_W-1:0]      req_doc_index,
   input  wire logic [WORD_W-1:0]     req_word_id,
   input  wire logic [TOPIC_W-1:0]    req_old_topic,
   input  wire logic [RAND_W-1:0]     req_random_fraction,
   output logic                       rsp_valid,
   output logic [TOPIC_W-1:0]         rsp_new_topic,
   output logic                       rsp_count_error,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int DX_W   = idx_w(MAX_DOCS);
   localparam int WX_W   = idx_w(MAX_VOCAB);
   localparam int TX_W   = idx_w(MAX_TOPICS);
   localparam int KK_W   = TX_W + 1;
   localparam int CB     = COUNT_BITS;
   localparam int OP_W   = CB + FRAC_W + 1;
   localparam int PROD_W = 2 * OP_W;
   localparam int VB_W   = VSIZE_W + PRIOR_W;
   localparam int THR_W  = WGT_W + RAND_W;
   localparam int STEP_W = 4;
   localparam logic [CB-1:0]    CNT_MAX = '1;
   localparam logic [TOT_W-1:0] TOT_MAX = '1;
   localparam logic [WGT_W-1:0] WGT_MAX = '1;

   typedef enum logic [15:0] {
      ST_CLEAR  = 16'h0001,
      ST_IDLE   = 16'h0002,
      ST_WRAP   = 16'h0004,
      ST_MOD    = 16'h0008,
      ST_OLD    = 16'h0010,
      ST_RM_RD  = 16'h0020,
      ST_RM_WR  = 16'h0040,
      ST_W_RD   = 16'h0080,
      ST_W_MST  = 16'h0100,
      ST_W_MUL  = 16'h0200,
      ST_W_DIV  = 16'h0400,
      ST_THR    = 16'h0800,
      ST_CMP_RD = 16'h1000,
      ST_CMP    = 16'h2000,
      ST_ADD_RD = 16'h4000,
      ST_ADD_WR = 16'h8000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [NTOP_W-1:0]  ntop_ff;
   logic [VSIZE_W-1:0] vsize_ff;
   logic [PRIOR_W-1:0] alpha_ff, beta_ff;

   // request registers
   logic               act_ff, act_in;
   logic [DOC_W-1:0]   doc_ff, doc_in;
   logic [WORD_W-1:0]  word_ff, word_in;
   logic [TOPIC_W-1:0] old_ff, old_in;
   logic [RAND_W-1:0]  rand_ff, rand_in;
   logic [KK_W-1:0]    kk_ff, kk_in, kk_cfg;
   logic [VB_W-1:0]    vbeta_ff, vbeta_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   // loop state
   logic [TX_W-1:0]    tsel_ff, tsel_in;
   logic [TX_W-1:0]    cidx_ff, cidx_in;
   logic [DIV_W-1:0]   dvs_ff, dvs_in;
   logic               pz_ff, pz_in;
   logic [WGT_W-1:0]   total_ff, total_in;
   logic [WGT_W-1:0]   thr_ff, thr_in;
   logic               err_ff, err_in;

   // response registers
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TOPIC_W-1:0] rsp_topic_ff, rsp_topic_in;
   logic               rsp_err_ff, rsp_err_in;

   // cumulative weight memory
   logic [WGT_W-1:0]   cum_mem [MAX_TOPICS];
   logic [WGT_W-1:0]   cq_ff;
   logic               cum_we;

   // unit connections
   logic               mul_start, mul_done;
   logic [OP_W-1:0]    mul_a, mul_b;
   logic [PROD_W-1:0]  mul_prod;
   logic               thr_start, thr_done;
   logic [THR_W-1:0]   thr_prod;
   logic               div_start, div_done, div_ovf;
   logic [PROD_W-1:0]  div_dvd;
   logic [DIV_W-1:0]   div_dsr;
   logic [WGT_W-1:0]   div_q;
   logic [DIV_W-1:0]   div_rem;

   // count store connections
   logic               cnt_wr;
   logic [CB-1:0]      dt_wd, tw_wd, dt_q, tw_q;
   logic [TOT_W-1:0]   tt_wd, tt_q;
   logic               clear_done;

   logic [DIV_W-1:0]   d_cur;
   logic [WGT_W-1:0]   wgt;
   logic [WGT_W:0]     sum;
   logic [WGT_W-1:0]   tot_new;
   logic [31:0]        wrap_w, wrap_d;
   logic               last_k, last_c;
   logic               dec_err, inc_err;

   // topics in use, clamped to 1..MAX_TOPICS
   always_comb begin
      if (ntop_ff == '0) begin
         kk_cfg = KK_W'(1);
      end else if (32'(ntop_ff) > MAX_TOPICS) begin
         kk_cfg = KK_W'(MAX_TOPICS);
      end else begin
         kk_cfg = KK_W'(ntop_ff);
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ntop_ff  <= NTOP_RST;
         vsize_ff <= VSIZE_RST;
         alpha_ff <= ALPHA_RST;
         beta_ff  <= BETA_RST;
      end else if (csr_write) begin
         unique case (csr_idx_type'(csr_index))
            CSR_NUM_TOPICS: ntop_ff  <= csr_data[NTOP_W-1:0];
            CSR_VOCAB_SIZE: vsize_ff <= csr_data[VSIZE_W-1:0];
            CSR_ALPHA:      alpha_ff <= csr_data[PRIOR_W-1:0];
            CSR_BETA:       beta_ff  <= csr_data[PRIOR_W-1:0];
            default: ;
         endcase
      end
   end

   // datapath terms
   assign d_cur   = DIV_W'({tt_q, {FRAC_W{1'b0}}}) + DIV_W'(vbeta_ff);
   assign wgt     = (dvs_ff == '0) ? (pz_ff ? '0 : WGT_MAX)
                                   : (div_ovf ? WGT_MAX : div_q);
   assign sum     = {1'b0, total_ff} + {1'b0, wgt};
   assign tot_new = sum[WGT_W] ? WGT_MAX : sum[WGT_W-1:0];
   assign wrap_w  = 32'(MAX_VOCAB) << step_ff;
   assign wrap_d  = 32'(MAX_DOCS) << step_ff;
   assign last_k  = (KK_W'(tsel_ff) == kk_ff - 1'b1);
   assign last_c  = (KK_W'(cidx_ff) == kk_ff - 1'b1);
   assign mul_a   = OP_W'({tw_q, {FRAC_W{1'b0}}}) + OP_W'(beta_ff);
   assign mul_b   = OP_W'({dt_q, {FRAC_W{1'b0}}}) + OP_W'(alpha_ff);

   // count updates: remove at the old topic, add at the chosen one
   always_comb begin
      dec_err = (dt_q == '0) | (tw_q == '0) | (tt_q == '0);
      inc_err = (dt_q == CNT_MAX) | (tw_q == CNT_MAX) | (tt_q == TOT_MAX);
      if (state_ff == ST_RM_WR) begin
         dt_wd = (dt_q == '0) ? '0 : dt_q - 1'b1;
         tw_wd = (tw_q == '0) ? '0 : tw_q - 1'b1;
         tt_wd = (tt_q == '0) ? '0 : tt_q - 1'b1;
      end else begin
         dt_wd = (dt_q == CNT_MAX) ? dt_q : dt_q + 1'b1;
         tw_wd = (tw_q == CNT_MAX) ? tw_q : tw_q + 1'b1;
         tt_wd = (tt_q == TOT_MAX) ? tt_q : tt_q + 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      doc_in       = doc_ff;
      word_in      = word_ff;
      old_in       = old_ff;
      rand_in      = rand_ff;
      kk_in        = kk_ff;
      vbeta_in     = vbeta_ff;
      step_in      = step_ff;
      tsel_in      = tsel_ff;
      cidx_in      = cidx_ff;
      dvs_in       = dvs_ff;
      pz_in        = pz_ff;
      total_in     = total_ff;
      thr_in       = thr_ff;
      err_in       = err_ff;
      rsp_valid_in = 1'b0;
      rsp_topic_in = rsp_topic_ff;
      rsp_err_in   = rsp_err_ff;
      mul_start    = 1'b0;
      thr_start    = 1'b0;
      div_start    = 1'b0;
      div_dvd      = PROD_W'(mul_prod);
      div_dsr      = d_cur;
      cnt_wr       = 1'b0;
      cum_we       = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            if (clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               act_in   = req_action;
               doc_in   = req_doc_index;
               word_in  = req_word_id;
               old_in   = req_old_topic;
               rand_in  = req_random_fraction;
               kk_in    = kk_cfg;
               vbeta_in = VB_W'(vsize_ff) * VB_W'(beta_ff);
               step_in  = STEP_W'(WORD_W - 1);
               err_in   = 1'b0;
               state_in = ST_WRAP;
            end
         end
         // bring doc and word into range, one binary step per cycle
         ST_WRAP: begin
            if (32'(word_ff) >= wrap_w) begin
               word_in = word_ff - WORD_W'(wrap_w);
            end
            if (32'(doc_ff) >= wrap_d) begin
               doc_in = doc_ff - DOC_W'(wrap_d);
            end
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               div_start = 1'b1;
               div_dsr   = DIV_W'(kk_ff);
               if (act_ff) begin
                  div_dvd  = PROD_W'(old_ff);
                  state_in = ST_OLD;
               end else begin
                  div_dvd  = PROD_W'(rand_ff);
                  state_in = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            if (div_done) begin
               tsel_in  = TX_W'(div_rem);
               state_in = ST_ADD_RD;
            end
         end
         ST_OLD: begin
            if (div_done) begin
               tsel_in  = TX_W'(div_rem);
               state_in = ST_RM_RD;
            end
         end
         ST_RM_RD: begin
            state_in = ST_RM_WR;
         end
         ST_RM_WR: begin
            cnt_wr   = 1'b1;
            err_in   = err_ff | dec_err;
            tsel_in  = '0;
            total_in = '0;
            state_in = ST_W_RD;
         end
         // weight loop over topics
         ST_W_RD: begin
            state_in = ST_W_MST;
         end
         ST_W_MST: begin
            mul_start = 1'b1;
            state_in  = ST_W_MUL;
         end
         ST_W_MUL: begin
            if (mul_done) begin
               dvs_in    = d_cur;
               pz_in     = (mul_prod == '0);
               div_start = 1'b1;
               state_in  = ST_W_DIV;
            end
         end
         ST_W_DIV: begin
            if (div_done) begin
               cum_we   = 1'b1;
               total_in = tot_new;
               if (last_k) begin
                  thr_start = 1'b1;
                  state_in  = ST_THR;
               end else begin
                  tsel_in  = tsel_ff + 1'b1;
                  state_in = ST_W_RD;
               end
            end
         end
         ST_THR: begin
            if (thr_done) begin
               thr_in   = thr_prod[THR_W-1:RAND_W];
               cidx_in  = '0;
               state_in = ST_CMP_RD;
            end
         end
         // compare pass: first cumulative weight reaching the threshold
         ST_CMP_RD: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if ((cq_ff >= thr_ff) || last_c) begin
               tsel_in  = cidx_ff;
               state_in = ST_ADD_RD;
            end else begin
               cidx_in  = cidx_ff + 1'b1;
               state_in = ST_CMP_RD;
            end
         end
         ST_ADD_RD: begin
            state_in = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            cnt_wr       = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_topic_in = TOPIC_W'(tsel_ff);
            rsp_err_in   = err_ff | inc_err;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      doc_ff       <= doc_in;
      word_ff      <= word_in;
      old_ff       <= old_in;
      rand_ff      <= rand_in;
      kk_ff        <= kk_in;
      vbeta_ff     <= vbeta_in;
      step_ff      <= step_in;
      tsel_ff      <= tsel_in;
      cidx_ff      <= cidx_in;
      dvs_ff       <= dvs_in;
      pz_ff        <= pz_in;
      total_ff     <= total_in;
      thr_ff       <= thr_in;
      err_ff       <= err_in;
      rsp_topic_ff <= rsp_topic_in;
      rsp_err_ff   <= rsp_err_in;
   end

   // cumulative weights, written in the loop and read in the compare pass
   always_ff @(posedge clock) begin
      if (cum_we) begin
         cum_mem[tsel_ff] <= tot_new;
      end
      cq_ff <= cum_mem[cidx_ff];
   end

   lgs_mul #(
      .A_W (OP_W),
      .B_W (OP_W)
   ) u_wmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   lgs_mul #(
      .A_W (WGT_W),
      .B_W (RAND_W)
   ) u_tmul (
      .clock   (clock),
      .reset   (reset),
      .start   (thr_start),
      .a       (tot_new),
      .b       (rand_ff),
      .done    (thr_done),
      .product (thr_prod)
   );

   lgs_div #(
      .N_W (PROD_W),
      .D_W (DIV_W),
      .Q_W (WGT_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dsr),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_rem),
      .overflow  (div_ovf)
   );

   lgs_counts #(
      .MAX_TOPICS (MAX_TOPICS),
      .MAX_VOCAB  (MAX_VOCAB),
      .MAX_DOCS   (MAX_DOCS),
      .COUNT_BITS (COUNT_BITS)
   ) u_counts (
      .clock      (clock),
      .reset      (reset),
      .doc        (DX_W'(doc_ff)),
      .word       (WX_W'(word_ff)),
      .topic      (tsel_ff),
      .wr_en      (cnt_wr),
      .dt_wdata   (dt_wd),
      .tw_wdata   (tw_wd),
      .tt_wdata   (tt_wd),
      .dt_q       (dt_q),
      .tw_q       (tw_q),
      .tt_q       (tt_q),
      .clear_done (clear_done)
   );

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_new_topic   = rsp_topic_ff;
   assign rsp_count_error = rsp_err_ff;

endmodule

`default_nettype wire

// ----- rtl/core/lgs_checker.sv -----
// ----------------------------------------------------------------------------
// lgs_checker
// Port-level checks of the topic sampler request/response sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid
);

   // a taken request keeps the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but block not busy");

   // a response only shows while the block is free
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // never two responses in a row
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response repeated");

   // no response in the cycle after a request is taken
   a_rsp_not_early: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("response too early");

endmodule

bind lda_gibbs_topic_sampler lgs_checker u_lgs_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LDA Gibbs topic sampler. A queue of commands
// (token requests, register writes and drain points) feeds a clocked driver.
// Each accepted request is run through a local model of the count stores and
// the weighted topic draw. The monitor checks every response against the
// oldest predicted one.
// ----------------------------------------------------------------------------

module testbench;
   import lgs_pkg::*;

   localparam int NT = LGS_MAX_TOPICS;
   localparam int NV = LGS_MAX_VOCAB;
   localparam int ND = LGS_MAX_DOCS;
   localparam int CNT_MAX = (1 << LGS_COUNT_BITS) - 1;
   localparam int TOT_MAX = (1 << TOT_W) - 1;
   localparam logic [127:0] WGT_MAX = (128'd1 << WGT_W) - 1;

   typedef struct packed {
      logic                action;
      logic [DOC_W-1:0]    doc;
      logic [WORD_W-1:0]   word;
      logic [TOPIC_W-1:0]  old;
      logic [RAND_W-1:0]   rnd;
   } token_type;

   typedef enum {CMD_TOKEN, CMD_TRACKED, CMD_DRAIN, CMD_CSR} cmd_kind_type;

   typedef struct {
      cmd_kind_type     kind;
      token_type        tok;
      csr_idx_type      idx;
      logic [CSR_DATA_W-1:0] data;
   } cmd_type;

   typedef struct packed {
      logic [TOPIC_W-1:0] topic;
      logic               err;
   } topic_rsp_type;

   typedef struct packed {
      logic [DOC_W-1:0]   doc;
      logic [WORD_W-1:0]  word;
      logic [TOPIC_W-1:0] topic;
   } placed_token_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_action = 1'b0;
   logic [DOC_W-1:0]      req_doc_index = '0;
   logic [WORD_W-1:0]     req_word_id = '0;
   logic [TOPIC_W-1:0]    req_old_topic = '0;
   logic [RAND_W-1:0]     req_random_fraction = '0;
   logic                  rsp_valid;
   logic [TOPIC_W-1:0]    rsp_new_topic;
   logic                  rsp_count_error;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   lda_gibbs_topic_sampler dut (.*);

   always #4 clock = ~clock;

   // model state: counts and register shadows
   int unsigned doc_topic_cnt [ND*NT];
   int unsigned topic_word_cnt [NT*NV];
   int unsigned topic_total [NT];
   int unsigned cfg_topics = NTOP_RST;
   int unsigned cfg_vocab  = VSIZE_RST;
   int unsigned cfg_alpha  = ALPHA_RST;
   int unsigned cfg_beta   = BETA_RST;

   cmd_type          pending_cmds [$];
   topic_rsp_type    expected_topics [$];
   placed_token_type placed_tokens [$];
   int               mismatches = 0;

   initial begin
      foreach (doc_topic_cnt[i]) doc_topic_cnt[i] = 0;
      foreach (topic_word_cnt[i]) topic_word_cnt[i] = 0;
      foreach (topic_total[i]) topic_total[i] = 0;
   end

   function automatic int unsigned count_up(int unsigned c, int unsigned maxv,
                                            inout logic err);
      if (c >= maxv) begin
         err = 1'b1;
         return maxv;
      end
      return c + 1;
   endfunction

   function automatic int unsigned count_down(int unsigned c, inout logic err);
      if (c == 0) begin
         err = 1'b1;
         return 0;
      end
      return c - 1;
   endfunction

   // topic draw and count update for one accepted request
   function automatic topic_rsp_type draw_topic(token_type t);
      int unsigned   kk, old, k, pick;
      int unsigned   d, w;
      logic          err, found;
      logic [127:0]  a, b, dv, prod, wt, total, thresh;
      logic [127:0]  cum [NT];
      topic_rsp_type res;
      kk = (cfg_topics == 0) ? 1 : (cfg_topics > NT) ? NT : cfg_topics;
      d = t.doc;
      w = t.word;
      err = 1'b0;
      if (!t.action) begin
         pick = t.rnd % kk;
      end else begin
         old = t.old % kk;
         doc_topic_cnt[d*NT+old] = count_down(doc_topic_cnt[d*NT+old], err);
         topic_word_cnt[old*NV+w] = count_down(topic_word_cnt[old*NV+w], err);
         topic_total[old] = count_down(topic_total[old], err);
         total = 0;
         for (k = 0; k < kk; k++) begin
            a = (128'(topic_word_cnt[k*NV+w]) << FRAC_W) + cfg_beta;
            b = (128'(doc_topic_cnt[d*NT+k]) << FRAC_W) + cfg_alpha;
            dv = (128'(topic_total[k]) << FRAC_W) + 128'(cfg_vocab) * cfg_beta;
            prod = a * b;
            if (dv == 0) begin
               wt = (prod == 0) ? 0 : WGT_MAX;
            end else begin
               wt = prod / dv;
               if (wt > WGT_MAX) wt = WGT_MAX;
            end
            total += wt;
            if (total > WGT_MAX) total = WGT_MAX;
            cum[k] = total;
         end
         thresh = (total * t.rnd) >> 32;
         pick = kk - 1;
         found = 1'b0;
         for (k = 0; k < kk; k++) begin
            if (!found && cum[k] >= thresh) begin
               pick = k;
               found = 1'b1;
            end
         end
      end
      doc_topic_cnt[d*NT+pick] = count_up(doc_topic_cnt[d*NT+pick], CNT_MAX, err);
      topic_word_cnt[pick*NV+w] = count_up(topic_word_cnt[pick*NV+w], CNT_MAX, err);
      topic_total[pick] = count_up(topic_total[pick], TOT_MAX, err);
      res.topic = pick[TOPIC_W-1:0];
      res.err = err;
      return res;
   endfunction

   // driver: one command at a time, random gaps, tracked tokens resolved late
   token_type cur_tok;
   int        cur_slot = -1;
   int        gap_left = 0;
   int        settle_left = 20;
   logic      no_gaps = 1'b0;

   always @(posedge clock) begin
      logic             nxt_start, nxt_wr;
      topic_rsp_type    res;
      cmd_type          c;
      token_type        t;
      placed_token_type pt;
      int               slot;
      nxt_start = start;
      nxt_wr = 1'b0;
      if (!reset) begin
         // request taken at this edge
         if (start && !busy) begin
            res = draw_topic(cur_tok);
            expected_topics.insert(expected_topics.size(), res);
            if (cur_slot >= 0)
               placed_tokens[cur_slot].topic = res.topic;
            else if (!cur_tok.action) begin
               pt.doc = cur_tok.doc;
               pt.word = cur_tok.word;
               pt.topic = res.topic;
               placed_tokens.insert(placed_tokens.size(), pt);
            end
            nxt_start = 1'b0;
            if ($urandom_range(0, 7) == 0) no_gaps = ~no_gaps;
            gap_left = no_gaps ? 0 : $urandom_range(0, 18);
         end
         if (!nxt_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_cmds.size() > 0) begin
               c = pending_cmds[0];
               case (c.kind)
                  CMD_DRAIN: begin
                     // hold off until every response is back, then settle
                     if (expected_topics.size() == 0) begin
                        if (settle_left == 0) begin
                           void'(pending_cmds.pop_front());
                           settle_left = 20;
                        end else begin
                           settle_left--;
                        end
                     end
                  end
                  CMD_CSR: begin
                     void'(pending_cmds.pop_front());
                     nxt_wr = 1'b1;
                     csr_index <= c.idx;
                     csr_data <= c.data;
                     case (c.idx)
                        CSR_NUM_TOPICS: cfg_topics = c.data[NTOP_W-1:0];
                        CSR_VOCAB_SIZE: cfg_vocab = c.data[VSIZE_W-1:0];
                        CSR_ALPHA:      cfg_alpha = c.data[PRIOR_W-1:0];
                        CSR_BETA:       cfg_beta = c.data[PRIOR_W-1:0];
                     endcase
                  end
                  default: begin
                     void'(pending_cmds.pop_front());
                     t = c.tok;
                     slot = -1;
                     if (c.kind == CMD_TRACKED) begin
                        if (placed_tokens.size() > 0) begin
                           slot = $urandom_range(0, placed_tokens.size() - 1);
                           t.action = 1'b1;
                           t.doc = placed_tokens[slot].doc;
                           t.word = placed_tokens[slot].word;
                           t.old = placed_tokens[slot].topic;
                        end else begin
                           t.action = 1'b0;
                        end
                     end
                     cur_tok = t;
                     cur_slot = slot;
                     req_action <= t.action;
                     req_doc_index <= t.doc;
                     req_word_id <= t.word;
                     req_old_topic <= t.old;
                     req_random_fraction <= t.rnd;
                     nxt_start = 1'b1;
                  end
               endcase
            end
         end
      end
      start <= nxt_start;
      csr_write <= nxt_wr;
   end

   // monitor: responses cannot stall, compare against oldest prediction
   always @(posedge clock) begin
      topic_rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (expected_topics.size() == 0) begin
            $error("unexpected response: new_topic %0d count_error %0d",
                   rsp_new_topic, rsp_count_error);
            mismatches++;
         end else begin
            exp_rsp = expected_topics.pop_front();
            if (rsp_new_topic !== exp_rsp.topic) begin
               $error("new_topic: expected %0d, actual %0d", exp_rsp.topic, rsp_new_topic);
               mismatches++;
            end
            if (rsp_count_error !== exp_rsp.err) begin
               $error("count_error: expected %0d, actual %0d",
                      exp_rsp.err, rsp_count_error);
               mismatches++;
            end
         end
      end
   end

   task automatic push_token(logic act, int doc, int word, int old, logic [31:0] rnd);
      cmd_type c;
      c.kind = CMD_TOKEN;
      c.tok = {act, doc[DOC_W-1:0], word[WORD_W-1:0], old[TOPIC_W-1:0], rnd};
      c.idx = CSR_NUM_TOPICS;
      c.data = '0;
      pending_cmds.insert(pending_cmds.size(), c);
   endtask

   task automatic push_tracked(logic [31:0] rnd);
      cmd_type c;
      c.kind = CMD_TRACKED;
      c.tok = {1'b1, 8'd0, 10'd0, 5'd0, rnd};
      c.idx = CSR_NUM_TOPICS;
      c.data = '0;
      pending_cmds.insert(pending_cmds.size(), c);
   endtask

   task automatic push_csr(csr_idx_type idx, logic [CSR_DATA_W-1:0] data);
      cmd_type c;
      c.kind = CMD_CSR;
      c.tok = '0;
      c.idx = idx;
      c.data = data;
      pending_cmds.insert(pending_cmds.size(), c);
   endtask

   task automatic push_drain();
      cmd_type c;
      c.kind = CMD_DRAIN;
      c.tok = '0;
      c.idx = CSR_NUM_TOPICS;
      c.data = '0;
      pending_cmds.insert(pending_cmds.size(), c);
   endtask

   // drain, write all registers, then a block of random requests
   task automatic run_phase(int ntop, int vsize, int alpha, int beta, int count);
      int n, sel, doc, word;
      push_drain();
      push_csr(CSR_NUM_TOPICS, ntop);
      push_csr(CSR_VOCAB_SIZE, vsize);
      push_csr(CSR_ALPHA, alpha);
      push_csr(CSR_BETA, beta);
      for (n = 0; n < count; n++) begin
         sel = $urandom_range(0, 9);
         // mostly a small corpus so counts grow, sometimes the full range
         doc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
         word = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15);
         if (sel < 6)
            push_tracked($urandom);
         else if (sel < 9)
            push_token(1'b0, doc, word, $urandom_range(0, 31), $urandom);
         else
            push_token(1'b1, doc, word, $urandom_range(0, 31), $urandom);
      end
   endtask

   // stimulus and end of test
   initial begin
      // directed requests on reset settings
      push_token(1'b0, 0, 0, 0, 32'h0);
      push_token(1'b0, 255, 1023, 31, 32'hFFFF_FFFF);
      push_token(1'b0, 3, 5, 0, 32'd31);
      push_token(1'b0, 3, 5, 0, 32'd64);
      push_tracked(32'h0);
      push_tracked(32'hFFFF_FFFF);
      push_tracked(32'h8000_0000);
      push_token(1'b1, 200, 700, 31, 32'h1234_5678);   // underflow on empty counts
      push_token(1'b1, 3, 5, 0, 32'h0);
      push_token(1'b1, 255, 1023, 31, 32'hFFFF_FFFF);
      push_drain();
      push_token(1'b1, 0, 0, 2, 32'h4000_0000);
      // single topic, then zero priors and zero vocabulary (zero divisor)
      run_phase(1, 1024, 65536, 655, 40);
      run_phase(0, 0, 0, 0, 40);
      run_phase(5, 2047, 24'hFFFFFF, 24'hFFFFFF, 80);
      run_phase(63, 1, 0, 655, 50);   // above max topics
      run_phase(8, 100, $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF), 180);
      run_phase(3, 7, 1, 1, 150);
      run_phase(32, 1024, 65536, 655, 90);
      run_phase(2, 1023, 24'hFFFFFF, 0, 110);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (pending_cmds.size() > 0 || start) @(posedge clock);
      while (expected_topics.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_topics.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // run limit
   initial begin
      #(200_000_000);
      $display("TEST FAILED");
      $finish;
   end

endmodule
